### hw/rtl/mts_pkg.sv
// Package for the markup token scanner: token kinds, status codes, scan modes,
// character constants, result types and byte-class helper functions.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package mts_pkg;

  localparam int unsigned MAX_TOKEN_LENGTH_DEF = 32'd65535;
  localparam int LEN_W = 16;

  // token kinds
  localparam logic [3:0] KIND_LT      = 4'd0;
  localparam logic [3:0] KIND_GT      = 4'd1;
  localparam logic [3:0] KIND_LBRACK  = 4'd2;
  localparam logic [3:0] KIND_RBRACK  = 4'd3;
  localparam logic [3:0] KIND_LPAREN  = 4'd4;
  localparam logic [3:0] KIND_RPAREN  = 4'd5;
  localparam logic [3:0] KIND_COLON   = 4'd6;
  localparam logic [3:0] KIND_COMMA   = 4'd7;
  localparam logic [3:0] KIND_EQUAL   = 4'd8;
  localparam logic [3:0] KIND_HASH    = 4'd9;
  localparam logic [3:0] KIND_IDENT   = 4'd10;
  localparam logic [3:0] KIND_NUMBER  = 4'd11;
  localparam logic [3:0] KIND_LITERAL = 4'd12;
  localparam logic [3:0] KIND_SPACE   = 4'd13;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR   = 2'd1;
  localparam logic [1:0] ST_NESTED     = 2'd2;
  localparam logic [1:0] ST_UNTERM     = 2'd3;

  // scan modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_LITERAL = 3'd3;
  localparam logic [2:0] MODE_SPACE   = 3'd4;

  // characters
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_LBRACK     = 8'h5B;
  localparam logic [7:0] CH_RBRACK     = 8'h5D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;

  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] length;
    logic [1:0]       status;
  } result_t;

  // results caused by one byte beat: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] kind;
  } single_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_LF;
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE || c == CH_DOLLAR;
  endfunction

  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit  = 1'b1;
    s.kind = KIND_LT;
    case (c)
      CH_LT:     s.kind = KIND_LT;
      CH_GT:     s.kind = KIND_GT;
      CH_LBRACK: s.kind = KIND_LBRACK;
      CH_RBRACK: s.kind = KIND_RBRACK;
      CH_LPAREN: s.kind = KIND_LPAREN;
      CH_RPAREN: s.kind = KIND_RPAREN;
      CH_COLON:  s.kind = KIND_COLON;
      CH_COMMA:  s.kind = KIND_COMMA;
      CH_EQUAL:  s.kind = KIND_EQUAL;
      CH_HASH:   s.kind = KIND_HASH;
      default:   s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/markup_token_scanner_unit.sv
// Markup token scanner, top level: input register, scan core, result register.
// Depends on mts_pkg, mts_scan_core and mts_result_buf.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one text byte or an end-of-text
//   mark per beat. Output channel (out_valid/out_stall) carries one token
//   result per beat: kind, length, status and last_result, which marks the
//   final result caused by an input beat.
//   A beat is registered at acceptance; once the result register can load,
//   the scan core updates the scan mode and run length and loads its results
//   into the result register, which offers them on the output channel.
//   Throughput is one input beat per cycle while each beat causes at most one
//   result and the receiver does not stall. A beat that closes a run and is
//   itself a complete token or error causes two results; the result register
//   then hands them out in turn and holds the input side until the second
//   leaves. Beats that cause no result produce nothing on the output.
//   Reset (rst, synchronous) empties both registers and returns the scanner to
//   idle with no pending token.
//   When the receiver stalls, the current result holds; the input register
//   keeps taking one more beat, then in_stall rises until a slot frees up.
module markup_token_scanner_unit #(
  parameter int unsigned MAX_TOKEN_LENGTH = mts_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_length,
  output logic [1:0]  status,
  output logic        last_result
);

  logic                  held;
  logic [7:0]            held_byte;
  logic                  held_eot;
  logic                  can_load;
  logic                  take;
  mts_pkg::result_pair_t pair;

  assign take     = held && can_load;
  assign in_stall = held && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
      held_eot  <= end_of_text;
    end
  end

  mts_scan_core #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (held_byte),
    .end_of_text(held_eot),
    .pair       (pair)
  );

  mts_result_buf u_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (take && (pair.count != 2'd0)),
    .pair        (pair),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .token_length(token_length),
    .status      (status),
    .last_result (last_result)
  );

endmodule

### hw/rtl/mts_scan_core.sv
// Scan core: holds the scan mode and pending run length and turns one byte
// beat into up to two results. Depends on mts_pkg.
module mts_scan_core #(
  parameter int unsigned MAX_TOKEN_LENGTH = mts_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_text,
  output mts_pkg::result_pair_t pair
);

  localparam logic [mts_pkg::LEN_W-1:0] LenCap =
    (MAX_TOKEN_LENGTH < 32'd65535) ? mts_pkg::LEN_W'(MAX_TOKEN_LENGTH) : 16'hFFFF;

  logic [2:0]                mode, mode_next;
  logic [mts_pkg::LEN_W-1:0] run_length, run_length_next;
  logic [mts_pkg::LEN_W-1:0] grown;

  mts_pkg::single_t single;
  logic             start_has;
  mts_pkg::result_t start_res;
  logic [2:0]       start_mode;
  logic [mts_pkg::LEN_W-1:0] start_len;
  mts_pkg::result_t run_res;
  logic             more;

  assign grown = (run_length < LenCap) ? run_length + 1'b1 : LenCap;

  // outcome of this byte as the first byte of a token
  always_comb begin
    single     = mts_pkg::single_kind(in_byte);
    start_has  = 1'b0;
    start_res  = '0;
    start_mode = mts_pkg::MODE_IDLE;
    start_len  = '0;
    if (single.hit) begin
      start_has        = 1'b1;
      start_res.kind   = single.kind;
      start_res.length = mts_pkg::LEN_W'(1);
      start_res.status = mts_pkg::ST_OK;
    end else if (mts_pkg::is_alpha(in_byte) || in_byte == mts_pkg::CH_UNDERSCORE) begin
      start_mode = mts_pkg::MODE_IDENT;
      start_len  = mts_pkg::LEN_W'(1);
    end else if (mts_pkg::is_digit(in_byte)) begin
      start_mode = mts_pkg::MODE_NUMBER;
      start_len  = mts_pkg::LEN_W'(1);
    end else if (mts_pkg::is_blank(in_byte)) begin
      start_mode = mts_pkg::MODE_SPACE;
      start_len  = mts_pkg::LEN_W'(1);
    end else if (in_byte == mts_pkg::CH_LBRACE) begin
      start_mode = mts_pkg::MODE_LITERAL;
      start_len  = mts_pkg::LEN_W'(1);
    end else begin
      start_has        = 1'b1;
      start_res.status = mts_pkg::ST_BAD_CHAR;
    end
  end

  always_comb begin
    run_res        = '0;
    run_res.length = run_length;
    run_res.status = mts_pkg::ST_OK;
    case (mode)
      mts_pkg::MODE_IDENT:  run_res.kind = mts_pkg::KIND_IDENT;
      mts_pkg::MODE_NUMBER: run_res.kind = mts_pkg::KIND_NUMBER;
      default:              run_res.kind = mts_pkg::KIND_SPACE;
    endcase
    case (mode)
      mts_pkg::MODE_IDENT:  more = mts_pkg::is_ident_tail(in_byte);
      mts_pkg::MODE_NUMBER: more = mts_pkg::is_digit(in_byte);
      default:              more = mts_pkg::is_blank(in_byte);
    endcase
  end

  always_comb begin
    mode_next       = mode;
    run_length_next = run_length;
    pair            = '0;
    if (end_of_text) begin
      mode_next       = mts_pkg::MODE_IDLE;
      run_length_next = '0;
      if (mode == mts_pkg::MODE_LITERAL) begin
        pair.count        = 2'd1;
        pair.first.status = mts_pkg::ST_UNTERM;
      end else if (mode == mts_pkg::MODE_IDENT || mode == mts_pkg::MODE_NUMBER ||
                   mode == mts_pkg::MODE_SPACE) begin
        pair.count = 2'd1;
        pair.first = run_res;
      end
    end else begin
      case (mode)
        mts_pkg::MODE_IDENT, mts_pkg::MODE_NUMBER, mts_pkg::MODE_SPACE: begin
          if (more) begin
            run_length_next = grown;
          end else begin
            // close the run, then treat this byte as a fresh start
            pair.first      = run_res;
            pair.second     = start_res;
            pair.count      = start_has ? 2'd2 : 2'd1;
            mode_next       = start_mode;
            run_length_next = start_len;
          end
        end
        mts_pkg::MODE_LITERAL: begin
          if (in_byte == mts_pkg::CH_RBRACE) begin
            pair.count        = 2'd1;
            pair.first.kind   = mts_pkg::KIND_LITERAL;
            pair.first.length = grown;
            pair.first.status = mts_pkg::ST_OK;
            mode_next         = mts_pkg::MODE_IDLE;
            run_length_next   = '0;
          end else if (in_byte == mts_pkg::CH_LBRACE) begin
            pair.count        = 2'd1;
            pair.first.status = mts_pkg::ST_NESTED;
            mode_next         = mts_pkg::MODE_IDLE;
            run_length_next   = '0;
          end else begin
            run_length_next = grown;
          end
        end
        default: begin
          pair.count      = {1'b0, start_has};
          pair.first      = start_res;
          mode_next       = start_mode;
          run_length_next = start_len;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mts_pkg::MODE_IDLE;
      run_length <= '0;
    end else if (take) begin
      mode       <= mode_next;
      run_length <= run_length_next;
    end
  end

endmodule

### hw/rtl/mts_result_buf.sv
// Result register: holds the one or two results of a byte beat and hands
// them out one beat at a time. Depends on mts_pkg.
module mts_result_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mts_pkg::result_pair_t pair,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           token_kind,
  output logic [15:0]          token_length,
  output logic [1:0]           status,
  output logic                 last_result
);

  logic             full;
  logic             two;
  logic             sel;
  mts_pkg::result_t res0, res1, cur;

  assign last_result = !two || sel;
  assign can_load    = !full || (!out_stall && last_result);
  assign cur         = sel ? res1 : res0;
  assign out_valid   = full;
  assign token_kind   = cur.kind;
  assign token_length = cur.length;
  assign status       = cur.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      sel  <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
      sel  <= 1'b0;
    end else if (full && !out_stall) begin
      // advance to the second result, or drain
      if (!last_result) begin
        sel <= 1'b1;
      end else begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res0 <= pair.first;
      res1 <= pair.second;
      two  <= (pair.count == 2'd2);
    end
  end

endmodule

### hw/rtl/mts_checker.sv
// Port-level checker for the markup token scanner, bound to the top level.
// Depends on markup_token_scanner_unit and mts_pkg.
module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  token_kind,
  input logic [15:0] token_length,
  input logic [1:0]  status,
  input logic        last_result
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mts_pkg::ST_OK |-> token_kind == 4'd0 && token_length == 16'd0)
    else $error("error result with nonzero kind or length");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mts_pkg::ST_OK |-> last_result)
    else $error("error result not last of its beat");

  // the first of two results is always a closed run
  a_first_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> status == mts_pkg::ST_OK &&
      token_kind >= mts_pkg::KIND_IDENT && token_kind <= mts_pkg::KIND_SPACE &&
      token_length != 16'd0)
    else $error("first of two results is not a run token");

  // hold the input only while a result beat is waiting to leave
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && (out_stall || !last_result))
    else $error("input stalled with no result beat waiting");

endmodule

bind markup_token_scanner_unit mts_checker u_mts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .token_kind  (token_kind),
  .token_length(token_length),
  .status      (status),
  .last_result (last_result)
);

### bench/tb_top.sv
// Self-checking bench for markup_token_scanner_unit: a directed byte table and
// a random token stream, scored by a token predictor and pinned table rows.
// Depends on mts_pkg (codes and characters) and the scanner RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int unsigned MAX_LEN = MAX_TOKEN_LENGTH_DEF;
  localparam logic [15:0] TOKEN_CAP = (MAX_LEN < 32'd65535) ? 16'(MAX_LEN) : 16'hFFFF;
  localparam logic [3:0] NO_KIND = 4'd0;  // error results carry kind zero
  localparam int RANDOM_BEATS = 1050;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] len;
    logic [1:0]  status;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic        pin;
    logic [3:0]  kind;
    logic [15:0] len;
    logic [1:0]  st;
  } plan_row_t;

  // Pinned rows carry the final token of the beat; the rest go to the predictor.
  localparam plan_row_t PLAN [26] = '{
    '{CH_LT,         1'b0, 1'b1, KIND_LT,      16'd1, ST_OK},
    '{CH_GT,         1'b0, 1'b1, KIND_GT,      16'd1, ST_OK},
    '{CH_LBRACK,     1'b0, 1'b1, KIND_LBRACK,  16'd1, ST_OK},
    '{CH_RBRACK,     1'b0, 1'b1, KIND_RBRACK,  16'd1, ST_OK},
    '{CH_LPAREN,     1'b0, 1'b1, KIND_LPAREN,  16'd1, ST_OK},
    '{CH_RPAREN,     1'b0, 1'b1, KIND_RPAREN,  16'd1, ST_OK},
    '{CH_COLON,      1'b0, 1'b1, KIND_COLON,   16'd1, ST_OK},
    '{CH_COMMA,      1'b0, 1'b1, KIND_COMMA,   16'd1, ST_OK},
    '{CH_EQUAL,      1'b0, 1'b1, KIND_EQUAL,   16'd1, ST_OK},
    '{CH_HASH,       1'b0, 1'b1, KIND_HASH,    16'd1, ST_OK},
    '{8'h00,         1'b0, 1'b1, NO_KIND,      16'd0, ST_BAD_CHAR},
    '{CH_UNDERSCORE, 1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_DOLLAR,     1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{8'h39,         1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{8'hFF,         1'b0, 1'b1, NO_KIND,      16'd0, ST_BAD_CHAR},
    '{8'h30,         1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_LBRACE,     1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{8'h00,         1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_RBRACE,     1'b0, 1'b1, KIND_LITERAL, 16'd3, ST_OK},
    '{CH_SPACE,      1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_TAB,        1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_LBRACE,     1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{CH_LBRACE,     1'b0, 1'b1, NO_KIND,      16'd0, ST_NESTED},
    '{CH_LBRACE,     1'b0, 1'b0, NO_KIND,      16'd0, ST_OK},
    '{8'hFF,         1'b1, 1'b1, NO_KIND,      16'd0, ST_UNTERM},
    '{8'h00,         1'b1, 1'b0, NO_KIND,      16'd0, ST_OK}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [15:0] token_length;
  logic [1:0]  status;
  logic        last_result;

  // scanner state as the predictor sees it
  logic [2:0]  scan_state;
  logic [15:0] pend_len;
  token_t      step_buf [2];
  int          step_n;
  token_t      tokens_due [$];

  logic        pin_on;
  token_t      pin_tok;
  logic        hold_req;
  int          burst_left;
  int          beats_sent;
  int          beats_taken;
  int          tokens_seen;
  int          error_tokens;
  int          errors;

  markup_token_scanner_unit #(
    .MAX_TOKEN_LENGTH(MAX_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_length(token_length),
    .status(status),
    .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---- character classes ----
  function automatic logic ch_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic ch_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic ch_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic ch_word_tail(input logic [7:0] c);
    return ch_letter(c) || ch_digit(c) || c == CH_UNDERSCORE || c == CH_DOLLAR;
  endfunction

  // {hit, kind} for the ten one-byte tokens
  function automatic logic [4:0] punct_code(input logic [7:0] c);
    case (c)
      CH_LT:     return {1'b1, KIND_LT};
      CH_GT:     return {1'b1, KIND_GT};
      CH_LBRACK: return {1'b1, KIND_LBRACK};
      CH_RBRACK: return {1'b1, KIND_RBRACK};
      CH_LPAREN: return {1'b1, KIND_LPAREN};
      CH_RPAREN: return {1'b1, KIND_RPAREN};
      CH_COLON:  return {1'b1, KIND_COLON};
      CH_COMMA:  return {1'b1, KIND_COMMA};
      CH_EQUAL:  return {1'b1, KIND_EQUAL};
      CH_HASH:   return {1'b1, KIND_HASH};
      default:   return 5'd0;
    endcase
  endfunction

  function automatic logic can_start(input logic [7:0] c);
    logic [4:0] p;
    p = punct_code(c);
    return p[4] || ch_letter(c) || ch_digit(c) || ch_blank(c) ||
           c == CH_UNDERSCORE || c == CH_LBRACE;
  endfunction

  // ---- token predictor ----
  function automatic logic [15:0] lengthen(input logic [15:0] n);
    return (n < TOKEN_CAP) ? n + 16'd1 : TOKEN_CAP;
  endfunction

  function automatic logic [3:0] run_token_kind(input logic [2:0] m);
    case (m)
      MODE_IDENT:  return KIND_IDENT;
      MODE_NUMBER: return KIND_NUMBER;
      default:     return KIND_SPACE;
    endcase
  endfunction

  function automatic token_t make_token(input logic [3:0] k, input logic [15:0] n,
                                        input logic [1:0] st);
    token_t t;
    t.kind = k;
    t.len = n;
    t.status = st;
    t.last = 1'b1;
    return t;
  endfunction

  function automatic void stage_token(input logic [3:0] k, input logic [15:0] n,
                                      input logic [1:0] st);
    step_buf[step_n] = make_token(k, n, st);
    step_buf[step_n].last = 1'b0;
    step_n++;
  endfunction

  // byte seen while idle
  function automatic void open_token(input logic [7:0] c);
    logic [4:0] p;
    p = punct_code(c);
    if (p[4]) begin
      stage_token(p[3:0], 16'd1, ST_OK);
    end else if (ch_letter(c) || c == CH_UNDERSCORE) begin
      scan_state = MODE_IDENT;
      pend_len = 16'd1;
    end else if (ch_digit(c)) begin
      scan_state = MODE_NUMBER;
      pend_len = 16'd1;
    end else if (ch_blank(c)) begin
      scan_state = MODE_SPACE;
      pend_len = 16'd1;
    end else if (c == CH_LBRACE) begin
      scan_state = MODE_LITERAL;
      pend_len = 16'd1;
    end else begin
      stage_token(NO_KIND, 16'd0, ST_BAD_CHAR);
    end
  endfunction

  function automatic void tokenize_beat(input logic [7:0] c, input logic eot,
                                        input logic pin, input token_t want);
    logic grows;
    step_n = 0;
    if (eot) begin
      if (scan_state == MODE_LITERAL)
        stage_token(NO_KIND, 16'd0, ST_UNTERM);
      else if (scan_state != MODE_IDLE)
        stage_token(run_token_kind(scan_state), pend_len, ST_OK);
      scan_state = MODE_IDLE;
      pend_len = 16'd0;
    end else if (scan_state == MODE_IDLE) begin
      open_token(c);
    end else if (scan_state == MODE_LITERAL) begin
      if (c == CH_RBRACE) begin
        stage_token(KIND_LITERAL, lengthen(pend_len), ST_OK);
        scan_state = MODE_IDLE;
        pend_len = 16'd0;
      end else if (c == CH_LBRACE) begin
        stage_token(NO_KIND, 16'd0, ST_NESTED);
        scan_state = MODE_IDLE;
        pend_len = 16'd0;
      end else begin
        pend_len = lengthen(pend_len);
      end
    end else begin
      case (scan_state)
        MODE_IDENT:  grows = ch_word_tail(c);
        MODE_NUMBER: grows = ch_digit(c);
        default:     grows = ch_blank(c);
      endcase
      if (grows) begin
        pend_len = lengthen(pend_len);
      end else begin
        // close the run, then treat the byte as a fresh start
        stage_token(run_token_kind(scan_state), pend_len, ST_OK);
        scan_state = MODE_IDLE;
        pend_len = 16'd0;
        open_token(c);
      end
    end
    if (step_n > 0) begin
      step_buf[step_n - 1].last = 1'b1;
      if (pin) step_buf[step_n - 1] = want;
    end
    for (int k = 0; k < step_n; k++) tokens_due.push_back(step_buf[k]);
  endfunction

  // ---- scoreboard ----
  task automatic flag_field(input string field, input int exp_val, input int got_val);
    errors++;
    if (errors <= MAX_REPORTS)
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    token_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (status != ST_OK) error_tokens++;
        if (tokens_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("token with nothing expected: kind %0d length %0d status %0d",
                   token_kind, token_length, status);
        end else begin
          want = tokens_due.pop_front();
          if (token_kind !== want.kind) flag_field("token_kind", want.kind, token_kind);
          if (token_length !== want.len) flag_field("token_length", want.len, token_length);
          if (status !== want.status) flag_field("status", want.status, status);
          if (last_result !== want.last) flag_field("last_result", want.last, last_result);
        end
      end
      if (in_valid && !in_stall) begin
        tokenize_beat(in_byte, end_of_text, pin_on, pin_tok);
        beats_taken++;
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_word_tail();
    case ($urandom_range(0, 5))
      0, 1:    return pick_letter();
      2:       return pick_digit();
      3:       return CH_UNDERSCORE;
      4:       return CH_DOLLAR;
      default: return pick_digit();
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 9))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_LPAREN;
      5:       return CH_RPAREN;
      6:       return CH_COLON;
      7:       return CH_COMMA;
      8:       return CH_EQUAL;
      default: return CH_HASH;
    endcase
  endfunction

  // any byte except braces
  function automatic logic [7:0] pick_free_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACE || b == CH_RBRACE);
    return b;
  endfunction

  function automatic logic [7:0] pick_bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (can_start(b));
    return b;
  endfunction

  // Present one beat at the falling edge, in bursts with random gaps between.
  task automatic send_beat(input logic [7:0] c, input logic eot, input logic pin,
                           input token_t want);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid = 1'b1;
    in_byte = c;
    end_of_text = eot;
    pin_on = pin;
    pin_tok = want;
    burst_left--;
    beats_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_byte(input logic [7:0] c);
    send_beat(c, 1'b0, 1'b0, '0);
  endtask

  task automatic push_eot();
    send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // ---- receiver: stall styles change now and then; long hold on request ----
  initial begin
    int cyc;
    int style;
    out_stall = 1'b0;
    cyc = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      cyc++;
      if (cyc % 97 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 9) < 3);
        2:       out_stall = ($urandom_range(0, 9) < 7);
        default: out_stall = (cyc % 8) >= 5;
      endcase
    end
  end

  // ---- watchdog: end the run if nothing moves for too long ----
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---- main sequence ----
  initial begin
    int n;
    int r;
    int start;
    int holds;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'd0;
    end_of_text = 1'b0;
    pin_on = 1'b0;
    pin_tok = '0;
    hold_req = 1'b0;
    burst_left = 0;
    beats_sent = 0;
    beats_taken = 0;
    tokens_seen = 0;
    error_tokens = 0;
    errors = 0;
    scan_state = MODE_IDLE;
    pend_len = 16'd0;
    step_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (PLAN[i])
      send_beat(PLAN[i].ch, PLAN[i].eot, PLAN[i].pin,
                make_token(PLAN[i].kind, PLAN[i].len, PLAN[i].st));

    // mostly well-formed tokens, with broken literals and stray bytes mixed in
    start = beats_sent;
    holds = 0;
    while (beats_sent - start < RANDOM_BEATS) begin
      if (holds < 2 && beats_sent - start >= 300 + holds * 400) begin
        hold_req = 1'b1;
        holds++;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_byte(pick_punct());
      end else if (r < 30) begin
        push_byte(($urandom_range(0, 7) == 0) ? CH_UNDERSCORE : pick_letter());
        n = $urandom_range(0, 10);
        repeat (n) push_byte(pick_word_tail());
      end else if (r < 42) begin
        n = $urandom_range(1, 8);
        repeat (n) push_byte(pick_digit());
      end else if (r < 54) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(pick_blank());
      end else if (r < 68) begin
        push_byte(CH_LBRACE);
        n = $urandom_range(0, 12);
        repeat (n) push_byte(pick_free_byte());
        r = $urandom_range(0, 9);
        if (r < 8) push_byte(CH_RBRACE);
        else if (r < 9) push_byte(CH_LBRACE);
        else push_eot();
      end else if (r < 76) begin
        push_eot();
      end else if (r < 86) begin
        push_byte(pick_bad_byte());
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    end_of_text = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Scanned %0d text beats; checked %0d tokens, %0d of them error reports.",
             beats_taken, tokens_seen, error_tokens);
    $display("Covered all one-byte tokens, runs, literals, error codes and %0d receiver holds.",
             holds);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
